// ===== rtl/core/tcp_slow_start_segmenter_assert.svh =====
// ----------------------------------------------------------------------------
// tcp slow start segmenter assertion macros
// concurrent property helpers used at the end of the top level
// ----------------------------------------------------------------------------
`ifndef TCP_SLOW_START_SEGMENTER_ASSERT_SVH
`define TCP_SLOW_START_SEGMENTER_ASSERT_SVH

// same-cycle implication
`define TSS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TSS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/tss_pkg.sv =====
// ----------------------------------------------------------------------------
// tss_pkg
// kinds, widths and result layout of the slow start segmenter
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int KIND_W   = 2;
  localparam int BYTES_W  = 31;
  localparam int MSS_W    = 14;
  localparam int WIN_W    = 16;
  localparam int DLY_W    = 16;
  localparam int QCNT_W   = 7;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

  localparam logic [KIND_W-1:0] KIND_SEND_FILE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SEND_TWO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GET       = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_MSS      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_WIN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RTT      = 2'd2;

  localparam logic [MSS_W-1:0] MSS_RESET = 14'd1460;
  localparam logic [WIN_W-1:0] WIN_RESET = 16'd1;
  localparam logic [DLY_W-1:0] RTT_RESET = 16'd100;
  localparam logic [WIN_W-1:0] WIN_MAX   = 16'hFFFF;
  localparam logic [BYTES_W-1:0] BACKLOG_MAX = 31'h7FFF_FFFF;
  localparam logic [WIN_W-1:0] SEND_TWO_LIMIT = 16'd2;

  // first member sits in the top bits
  typedef struct packed {
    logic [5:0]        pad;
    logic              source_empty;
    logic              overflow;
    logic [WIN_W-1:0]  window_now;
    logic              end_of_transfer;
    logic [DLY_W-1:0]  wake_after;
    logic              wake_request;
    logic [MSS_W-1:0]  segment_bytes;
    logic              segment_valid;
    logic [QCNT_W-1:0] queued_count;
  } result_t;

endpackage

// ===== rtl/core/tss_ram.sv =====
// ----------------------------------------------------------------------------
// tss_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module tss_ram #(
  parameter int WIDTH = 14,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/tcp_slow_start_segmenter.sv =====
// ----------------------------------------------------------------------------
// tcp_slow_start_segmenter
// slow start sender that cuts a byte backlog into queued segments
// ----------------------------------------------------------------------------
//  channel  | direction | handshake          | payload
//  in_      | slave     | in_tvalid/tready   | tuser kind, tdata byte_count
//  out_     | master    | out_tvalid/tready  | tdata result fields
//  cfg_     | write     | cfg_wr_en          | cfg_index, cfg_wdata
//
// send file into an active source runs ADD then FIN; get runs GRD (ram read), GPOP (pop),
// GROW (window growth) and FIN, or FIN alone on an empty queue; a push run queues one
// segment per cycle in PUSH through the shared adder and the queue ram write port, then FIN.
// rst_n is synchronous and clears control state; queue contents are not cleared.
// the next item is taken while a result waits; a stalled out_ side holds the
// sequencer in its final state until the result register frees up.
module tcp_slow_start_segmenter #(
  parameter int QUEUE_DEPTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // kind
  input  logic [tss_pkg::KIND_W-1:0]       in_tuser,
  // byte_count [30:0], zero pad
  input  logic [tss_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // queued_count, segment_valid, segment_bytes, wake_request, wake_after,
  // end_of_transfer, window_now, overflow, source_empty, zero pad
  output logic [tss_pkg::OUT_DATA_W-1:0]   out_tdata,
  input  logic                             cfg_wr_en,
  input  logic [tss_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [tss_pkg::CFG_DAT_W-1:0]    cfg_wdata
);

  import tss_pkg::*;

  localparam int PTR_W  = $clog2(QUEUE_DEPTH);
  localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0]  PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(QUEUE_DEPTH);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_ADD  = 3'd1;
  localparam logic [2:0] ST_PUSH = 3'd2;
  localparam logic [2:0] ST_GRD  = 3'd3;
  localparam logic [2:0] ST_GPOP = 3'd4;
  localparam logic [2:0] ST_GROW = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [MSS_W-1:0]   mss_r, mss_nxt;
  logic [WIN_W-1:0]   init_win_r, init_win_nxt;
  logic [DLY_W-1:0]   rtt_r, rtt_nxt;
  logic [BYTES_W-1:0] backlog_r, backlog_nxt;
  logic [WIN_W-1:0]   window_r, window_nxt;
  logic [WIN_W-1:0]   sent_r, sent_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [BYTES_W-1:0] bytes_r, bytes_nxt;
  logic [WIN_W-1:0]   limit_r, limit_nxt;
  logic [WIN_W-1:0]   done_r, done_nxt;
  logic               ovf_r, ovf_nxt;
  logic               seg_valid_r, seg_valid_nxt;
  logic [MSS_W-1:0]   seg_bytes_r, seg_bytes_nxt;
  logic               eot_r, eot_nxt;
  logic               out_valid_r, out_valid_nxt;
  result_t            result_r, result_nxt;

  logic               in_acc;
  logic [KIND_W-1:0]  in_kind;
  logic [BYTES_W-1:0] in_bytes;
  logic               src_empty;
  logic               q_full;
  logic [MSS_W-1:0]   seg_size;
  logic               rd_en;
  logic [MSS_W-1:0]   rd_data;
  logic               wr_en;

  // shared adder / subtractor
  logic [31:0]        alu_a, alu_b, alu_y;
  logic               alu_sub;

  assign in_kind   = in_tuser;
  assign in_bytes  = in_tdata[BYTES_W-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign src_empty = (backlog_r == '0) && (fill_r == '0);
  assign q_full    = (fill_r == FILL_MAX);
  assign seg_size  = (backlog_r < {17'd0, mss_r}) ? backlog_r[MSS_W-1:0] : mss_r;
  assign rd_en     = in_acc && (in_kind == KIND_GET);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = result_r;

  assign alu_y = alu_a + (alu_sub ? ~alu_b : alu_b) + {31'd0, alu_sub};

  always_comb begin
    alu_a   = {1'b0, backlog_r};
    alu_b   = {1'b0, bytes_r};
    alu_sub = 1'b0;
    unique case (state_r)
      ST_PUSH: begin
        alu_b   = {18'd0, seg_size};
        alu_sub = 1'b1;
      end
      ST_GROW: begin
        alu_a = {16'd0, window_r};
        alu_b = {16'd0, sent_r};
      end
      default: begin
      end
    endcase
  end

  tss_ram #(
    .WIDTH (MSS_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (seg_size),
    .rd_en   (rd_en),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  always_comb begin
    state_nxt     = state_r;
    mss_nxt       = mss_r;
    init_win_nxt  = init_win_r;
    rtt_nxt       = rtt_r;
    backlog_nxt   = backlog_r;
    window_nxt    = window_r;
    sent_nxt      = sent_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    fill_nxt      = fill_r;
    bytes_nxt     = bytes_r;
    limit_nxt     = limit_r;
    done_nxt      = done_r;
    ovf_nxt       = ovf_r;
    seg_valid_nxt = seg_valid_r;
    seg_bytes_nxt = seg_bytes_r;
    eot_nxt       = eot_r;
    out_valid_nxt = out_valid_r;
    result_nxt    = result_r;
    wr_en         = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_MSS:      mss_nxt = cfg_wdata[MSS_W-1:0];
        REG_INIT_WIN: begin
          init_win_nxt = cfg_wdata;
          window_nxt   = cfg_wdata;
        end
        REG_RTT:      rtt_nxt = cfg_wdata;
        default: begin
        end
      endcase
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          bytes_nxt     = in_bytes;
          done_nxt      = '0;
          ovf_nxt       = 1'b0;
          seg_valid_nxt = 1'b0;
          seg_bytes_nxt = '0;
          eot_nxt       = 1'b0;
          unique case (in_kind)
            KIND_SEND_FILE: begin
              if (src_empty) begin
                backlog_nxt = in_bytes;
                limit_nxt   = window_r;
                state_nxt   = ST_PUSH;
              end else begin
                state_nxt = ST_ADD;
              end
            end
            KIND_SEND_TWO: begin
              limit_nxt = SEND_TWO_LIMIT;
              state_nxt = ST_PUSH;
            end
            KIND_GET: begin
              state_nxt = (fill_r != '0) ? ST_GRD : ST_FIN;
            end
            default: state_nxt = ST_FIN;
          endcase
        end
      end
      ST_ADD: begin
        if (alu_y[31]) begin
          backlog_nxt = BACKLOG_MAX;
          ovf_nxt     = 1'b1;
        end else begin
          backlog_nxt = alu_y[BYTES_W-1:0];
        end
        state_nxt = ST_FIN;
      end
      ST_PUSH: begin
        if (done_r >= limit_r || seg_size == '0) begin
          state_nxt = ST_FIN;
        end else if (q_full) begin
          ovf_nxt   = 1'b1;
          state_nxt = ST_FIN;
        end else begin
          wr_en       = 1'b1;
          backlog_nxt = alu_y[BYTES_W-1:0];
          tail_nxt    = (tail_r == PTR_LAST) ? '0 : tail_r + PTR_W'(1);
          fill_nxt    = fill_r + FILL_W'(1);
          done_nxt    = done_r + WIN_W'(1);
        end
      end
      ST_GRD: begin
        state_nxt = ST_GPOP;
      end
      ST_GPOP: begin
        seg_valid_nxt = 1'b1;
        seg_bytes_nxt = rd_data;
        head_nxt      = (head_r == PTR_LAST) ? '0 : head_r + PTR_W'(1);
        fill_nxt      = fill_r - FILL_W'(1);
        if (sent_r != WIN_MAX) begin
          sent_nxt = sent_r + WIN_W'(1);
        end
        state_nxt = ST_GROW;
      end
      ST_GROW: begin
        if (src_empty) begin
          window_nxt = (alu_y[31:16] != '0) ? WIN_MAX : alu_y[WIN_W-1:0];
          sent_nxt   = '0;
          eot_nxt    = 1'b1;
        end
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt              = 1'b1;
          result_nxt.pad             = '0;
          result_nxt.source_empty    = src_empty;
          result_nxt.overflow        = ovf_r;
          result_nxt.window_now      = window_r;
          result_nxt.end_of_transfer = eot_r;
          result_nxt.wake_after      = seg_valid_r ? rtt_r : '0;
          result_nxt.wake_request    = seg_valid_r;
          result_nxt.segment_bytes   = seg_bytes_r;
          result_nxt.segment_valid   = seg_valid_r;
          result_nxt.queued_count    = done_r[QCNT_W-1:0];
          state_nxt                  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mss_r       <= MSS_RESET;
      init_win_r  <= WIN_RESET;
      rtt_r       <= RTT_RESET;
      backlog_r   <= '0;
      window_r    <= WIN_RESET;
      sent_r      <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mss_r       <= mss_nxt;
      init_win_r  <= init_win_nxt;
      rtt_r       <= rtt_nxt;
      backlog_r   <= backlog_nxt;
      window_r    <= window_nxt;
      sent_r      <= sent_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bytes_r     <= bytes_nxt;
    limit_r     <= limit_nxt;
    done_r      <= done_nxt;
    ovf_r       <= ovf_nxt;
    seg_valid_r <= seg_valid_nxt;
    seg_bytes_r <= seg_bytes_nxt;
    eot_r       <= eot_nxt;
    result_r    <= result_nxt;
  end

`include "tcp_slow_start_segmenter_assert.svh"

  `TSS_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FILL_MAX, "queue fill above depth")
  `TSS_ASSERT_NXT(a_acc_busy, in_acc, state_r != ST_IDLE, "sequencer idle after accept")
  `TSS_ASSERT_IMP(a_seg_wake, out_valid_r && result_r.segment_valid, result_r.wake_request, "segment without wake")
  `TSS_ASSERT_IMP(a_eot_empty, out_valid_r && result_r.end_of_transfer, result_r.source_empty, "end of transfer on busy source")

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// checks the slow start segmenter against a cycle-free shadow of its state:
// sender bursts, timer wakes and gets drive whole transfers under several
// register settings while both stream sides idle and stall at random
// ----------------------------------------------------------------------------

class slow_start_tracker;
  logic [13:0] mss;
  logic [15:0] rtt_delay;
  logic [30:0] backlog;
  logic [15:0] window;
  logic [15:0] sent_since_growth;
  logic [13:0] segment_sizes[$];
  tss_pkg::result_t pending_results[$];
  int unsigned queue_slots;
  bit overflowed;
  int unsigned mismatches;
  int unsigned results_checked;
  int unsigned overflow_items;
  int unsigned transfers_done;

  function new(int unsigned slots);
    queue_slots = slots;
    mss = tss_pkg::MSS_RESET;
    rtt_delay = tss_pkg::RTT_RESET;
    backlog = '0;
    window = tss_pkg::WIN_RESET;
    sent_since_growth = '0;
    mismatches = 0;
    results_checked = 0;
    overflow_items = 0;
    transfers_done = 0;
  endfunction

  function bit source_idle();
    return backlog == 0 && segment_sizes.size() == 0;
  endfunction

  function void write_reg(logic [tss_pkg::CFG_IDX_W-1:0] idx, logic [15:0] value);
    case (idx)
      tss_pkg::REG_MSS: mss = value[13:0];
      tss_pkg::REG_INIT_WIN: window = value;
      tss_pkg::REG_RTT: rtt_delay = value;
      default: ;
    endcase
  endfunction

  // cuts up to count segments off the backlog; stops when it runs dry or the queue fills
  function int unsigned cut_segments(longint unsigned count);
    int unsigned done;
    logic [30:0] size;
    longint unsigned i;
    done = 0;
    for (i = 0; i < count; i++) begin
      size = (backlog < 31'(mss)) ? backlog : 31'(mss);
      if (size == 0) break;
      if (segment_sizes.size() >= queue_slots) begin
        overflowed = 1'b1;
        break;
      end
      backlog -= size;
      segment_sizes.push_back(size[13:0]);
      done++;
    end
    return done;
  endfunction

  function void predict_segments(logic [1:0] kind, logic [30:0] bytes);
    tss_pkg::result_t r;
    longint unsigned segs;
    longint unsigned burst;
    longint unsigned total;
    longint unsigned grown;
    r = '0;
    overflowed = 1'b0;
    case (kind)
      tss_pkg::KIND_SEND_FILE: begin
        if (source_idle()) begin
          backlog = bytes;
          burst = 0;
          if (mss != 0) begin
            segs = (64'(bytes) + 64'(mss) - 64'd1) / 64'(mss);
            burst = (segs < 64'(window)) ? segs : 64'(window);
          end
          r.queued_count = 7'(cut_segments(burst));
        end else begin
          total = 64'(backlog) + 64'(bytes);
          if (total > 64'(tss_pkg::BACKLOG_MAX)) begin
            total = 64'(tss_pkg::BACKLOG_MAX);
            overflowed = 1'b1;
          end
          backlog = total[30:0];
        end
      end
      tss_pkg::KIND_SEND_TWO: r.queued_count = 7'(cut_segments(64'(tss_pkg::SEND_TWO_LIMIT)));
      tss_pkg::KIND_GET: begin
        if (segment_sizes.size() != 0) begin
          r.wake_request = 1'b1;
          r.wake_after = rtt_delay;
          r.segment_valid = 1'b1;
          r.segment_bytes = segment_sizes.pop_front();
          if (sent_since_growth != tss_pkg::WIN_MAX) sent_since_growth++;
          if (source_idle()) begin
            grown = 64'(window) + 64'(sent_since_growth);
            window = (grown > 64'(tss_pkg::WIN_MAX)) ? tss_pkg::WIN_MAX : grown[15:0];
            sent_since_growth = '0;
            r.end_of_transfer = 1'b1;
            transfers_done++;
          end
        end
      end
      default: ;
    endcase
    r.window_now = window;
    r.overflow = overflowed;
    r.source_empty = source_idle();
    if (overflowed) overflow_items++;
    pending_results.push_back(r);
  endfunction

  function string describe(tss_pkg::result_t r);
    return $sformatf("queued=%0d seg=%0d/%0d wake=%0d/%0d eot=%0d win=%0d ovf=%0d empty=%0d",
                     r.queued_count, r.segment_valid, r.segment_bytes, r.wake_request,
                     r.wake_after, r.end_of_transfer, r.window_now, r.overflow,
                     r.source_empty);
  endfunction

  function void check_result(logic [tss_pkg::OUT_DATA_W-1:0] data);
    tss_pkg::result_t got;
    tss_pkg::result_t want;
    bit bad;
    got = data;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with no item pending: %s", describe(got));
      return;
    end
    want = pending_results.pop_front();
    results_checked++;
    bad = got.queued_count !== want.queued_count || got.segment_valid !== want.segment_valid
       || got.segment_bytes !== want.segment_bytes || got.wake_request !== want.wake_request
       || got.wake_after !== want.wake_after || got.end_of_transfer !== want.end_of_transfer
       || got.window_now !== want.window_now || got.overflow !== want.overflow
       || got.source_empty !== want.source_empty;
    if (bad) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result %0d mismatch", results_checked);
        $display("  expected %s", describe(want));
        $display("  actual   %s", describe(got));
      end
    end
  endfunction
endclass

module tb;
  localparam int QUEUE_SLOTS = 64;
  localparam int unsigned CYCLE_LIMIT = 2000000;
  localparam logic [tss_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [tss_pkg::KIND_W-1:0] in_tuser = '0;
  logic [tss_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [tss_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_wr_en = 1'b0;
  logic [tss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tss_pkg::CFG_DAT_W-1:0] cfg_wdata = '0;

  slow_start_tracker tracker;
  bit idle_enable = 1'b1;
  int unsigned stall_left = 0;
  int unsigned items_sent = 0;
  int unsigned cycle_count = 0;

  tcp_slow_start_segmenter #(.QUEUE_DEPTH(QUEUE_SLOTS)) u_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tuser(in_tuser),
    .in_tdata(in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // result side back-pressure in bursts
  always @(posedge clk) begin
    if (idle_enable && stall_left == 0 && $urandom_range(0, 9) == 0)
      stall_left = $urandom_range(1, 15);
    if (stall_left != 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_result(out_tdata);
  end

  function automatic logic [30:0] random_bytes();
    return 31'($urandom);
  endfunction

  task automatic send_item(logic [1:0] kind, logic [30:0] bytes);
    if (idle_enable && $urandom_range(0, 7) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= {1'b0, bytes};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.predict_segments(kind, bytes);
    if (kind != KIND_UNUSED) items_sent++;
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    while (tracker.pending_results.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic load_regs(int unsigned mss, int unsigned win, int unsigned rtt);
    settle();
    cfg_wr_en <= 1'b1;
    cfg_index <= tss_pkg::REG_MSS;
    cfg_wdata <= 16'(mss);
    @(posedge clk);
    tracker.write_reg(tss_pkg::REG_MSS, 16'(mss));
    cfg_index <= tss_pkg::REG_INIT_WIN;
    cfg_wdata <= 16'(win);
    @(posedge clk);
    tracker.write_reg(tss_pkg::REG_INIT_WIN, 16'(win));
    cfg_index <= tss_pkg::REG_RTT;
    cfg_wdata <= 16'(rtt);
    @(posedge clk);
    tracker.write_reg(tss_pkg::REG_RTT, 16'(rtt));
    cfg_wr_en <= 1'b0;
  endtask

  // one transfer from an idle source until it runs empty again
  task automatic run_transfer(int unsigned max_bytes);
    int unsigned steps;
    int unsigned pick;
    steps = 0;
    if (tracker.source_idle()) begin
      pick = $urandom_range(0, 19);
      if (pick == 0) send_item(KIND_UNUSED, random_bytes());
      else if (pick == 1) send_item(tss_pkg::KIND_GET, random_bytes());
      else if (pick == 2) send_item(tss_pkg::KIND_SEND_TWO, random_bytes());
      send_item(tss_pkg::KIND_SEND_FILE, 31'($urandom_range(0, max_bytes)));
    end
    while (!tracker.source_idle() && steps < 3000) begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        send_item(KIND_UNUSED, random_bytes());
      else if (pick < 8)
        send_item(tss_pkg::KIND_SEND_FILE, 31'($urandom_range(0, 2 * tracker.mss)));
      else if (pick < 11)
        send_item(tss_pkg::KIND_GET, random_bytes());
      else if (tracker.segment_sizes.size() != 0 && pick < 72)
        send_item(tss_pkg::KIND_GET, random_bytes());
      else
        send_item(tss_pkg::KIND_SEND_TWO, random_bytes());
      steps++;
    end
  endtask

  task automatic run_phase(int unsigned items, int unsigned max_bytes);
    int unsigned phase_end;
    phase_end = items_sent + items;
    while (items_sent < phase_end) run_transfer(max_bytes);
  endtask

  initial begin
    int unsigned mss_pick;
    int unsigned p;
    tracker = new(QUEUE_SLOTS);
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: idle source, unknown kind, empty get and wake, one-segment window
    send_item(tss_pkg::KIND_GET, 31'h7FFF_FFFF);
    send_item(KIND_UNUSED, 31'h7FFF_FFFF);
    send_item(tss_pkg::KIND_SEND_TWO, '0);
    send_item(tss_pkg::KIND_SEND_FILE, '0);
    send_item(tss_pkg::KIND_SEND_FILE, 31'd3000);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_SEND_TWO, '0);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_SEND_FILE, 31'd1);
    send_item(tss_pkg::KIND_GET, '0);

    // one-byte segments with a maximal window: bursts hit a full queue
    load_regs(1, 65535, 0);
    run_phase(150, 150);

    // zero mss: nothing can be queued, backlog is left for the next phase
    idle_enable = 1'b0;
    load_regs(0, 3, 65535);
    send_item(tss_pkg::KIND_SEND_FILE, 31'd500);
    send_item(tss_pkg::KIND_SEND_TWO, '0);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_SEND_FILE, 31'd40);
    send_item(KIND_UNUSED, '0);
    idle_enable = 1'b1;

    // zero window: first burst is empty, wakes carry the transfer
    load_regs(16383, 0, $urandom_range(0, 65535));
    run_phase(150, 16383 * 6);

    load_regs(9000, 2, $urandom_range(0, 65535));
    run_phase(150, 9000 * 8);

    for (p = 0; p < 4; p++) begin
      idle_enable = ($urandom_range(0, 3) != 0);
      mss_pick = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 9000);
      load_regs(mss_pick, ($urandom_range(0, 4) == 0) ? $urandom_range(9, 200)
                                                     : $urandom_range(1, 8),
                $urandom_range(0, 65535));
      run_phase(140, mss_pick * $urandom_range(1, 10) + $urandom_range(0, mss_pick));
    end

    // closing stretch at full rate, ending in backlog saturation
    idle_enable = 1'b0;
    load_regs(tss_pkg::MSS_RESET, tss_pkg::WIN_RESET, tss_pkg::RTT_RESET);
    run_phase(60, 20000);
    settle();
    send_item(tss_pkg::KIND_SEND_FILE, 31'h4000_0000 | random_bytes());
    send_item(tss_pkg::KIND_SEND_FILE, 31'h7FFF_FFFF);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_SEND_TWO, '0);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_GET, '0);
    send_item(tss_pkg::KIND_SEND_FILE, 31'd1);

    settle();
    $display("sent %0d items over ten register settings, checked %0d results",
             items_sent, tracker.results_checked);
    $display("%0d transfers completed, %0d items hit a full queue or saturated backlog",
             tracker.transfers_done, tracker.overflow_items);
    if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/tss_pkg.sv
rtl/core/tss_ram.sv
rtl/core/tcp_slow_start_segmenter.sv
sim/tb.sv
